FILE: hw/rtl/cvtc_pkg.sv
package cvtc_pkg;

	// Field and counter widths
	localparam int unsigned IDX_W  = 5;
	localparam int unsigned CNT_W  = 9;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 8;

	// Only the low nibble of the sync width register sets the horizontal pulse width.
	localparam logic [3:0] SYNC_WIDTH_MASK = 4'hF;

	// Register numbers in the controller's register file
	localparam logic [IDX_W-1:0] R_HTOTAL     = 5'd0;
	localparam logic [IDX_W-1:0] R_HDISP      = 5'd1;
	localparam logic [IDX_W-1:0] R_HSYNC_POS  = 5'd2;
	localparam logic [IDX_W-1:0] R_SYNC_WIDTH = 5'd3;
	localparam logic [IDX_W-1:0] R_VTOTAL     = 5'd4;
	localparam logic [IDX_W-1:0] R_VDISP      = 5'd6;
	localparam logic [IDX_W-1:0] R_VSYNC_POS  = 5'd7;
	localparam logic [IDX_W-1:0] R_MAX_SCAN   = 5'd9;
	localparam logic [IDX_W-1:0] R_START_HI   = 5'd12;
	localparam logic [IDX_W-1:0] R_START_LO   = 5'd13;
	localparam logic [IDX_W-1:0] R_CURSOR_HI  = 5'd14;
	localparam logic [IDX_W-1:0] R_CURSOR_LO  = 5'd15;
	localparam logic [IDX_W-1:0] R_PEN_HI     = 5'd16;
	localparam logic [IDX_W-1:0] R_PEN_LO     = 5'd17;

	// Item kinds
	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_TICK  = 2'd2
	} mode_e;

	// Timing registers as seen by the counter logic
	typedef struct packed {
		logic [DATA_W-1:0] htotal;
		logic [DATA_W-1:0] hdisp;
		logic [DATA_W-1:0] hsync_pos;
		logic [3:0]        sync_width;
		logic [DATA_W-1:0] vtotal;
		logic [DATA_W-1:0] vdisp;
		logic [DATA_W-1:0] vsync_pos;
		logic [DATA_W-1:0] max_scan;
		logic [ADDR_W-1:0] start_addr;
	} cfg_t;

	// Reload of the row start address after a start address write
	typedef struct packed {
		logic              load;
		logic [ADDR_W-1:0] addr;
	} start_ld_t;

	// Timing outputs as they stand after an item
	typedef struct packed {
		logic              de;
		logic              hs;
		logic              vs;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  row;
	} tim_out_t;

endpackage

FILE: hw/rtl/cvtc_regs.sv
module cvtc_regs #(
	parameter int unsigned NUM_REGS = 18
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            commit,
	input  logic [1:0]                      mode,
	input  logic                            reg_select,
	input  logic [cvtc_pkg::DATA_W-1:0]     write_data,
	output cvtc_pkg::cfg_t                  cfg,
	output cvtc_pkg::start_ld_t             start_ld,
	output logic [cvtc_pkg::DATA_W-1:0]     read_data
);
	import cvtc_pkg::*;

	localparam int unsigned SelW = $clog2(NUM_REGS);

	logic [DATA_W-1:0] regs_q [NUM_REGS];
	logic [IDX_W-1:0]  idx_q;
	logic              wr_idx;
	logic              wr_data;
	logic              idx_in_range;

	// Decode the bus writes for this item.
	assign wr_idx       = commit && (mode == MODE_WRITE) && !reg_select;
	assign idx_in_range = {1'b0, idx_q} < (IDX_W + 1)'(NUM_REGS);
	assign wr_data      = commit && (mode == MODE_WRITE) && reg_select && idx_in_range;

	// Index register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (wr_idx) begin
			idx_q <= write_data[IDX_W-1:0];
		end
	end

	// Register file, one byte per entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_data) begin
			regs_q[idx_q[SelW-1:0]] <= write_data;
		end
	end

	// Fixed taps into the timing logic.
	always_comb begin
		cfg.htotal     = regs_q[R_HTOTAL[SelW-1:0]];
		cfg.hdisp      = regs_q[R_HDISP[SelW-1:0]];
		cfg.hsync_pos  = regs_q[R_HSYNC_POS[SelW-1:0]];
		cfg.sync_width = regs_q[R_SYNC_WIDTH[SelW-1:0]][3:0] & SYNC_WIDTH_MASK;
		cfg.vtotal     = regs_q[R_VTOTAL[SelW-1:0]];
		cfg.vdisp      = regs_q[R_VDISP[SelW-1:0]];
		cfg.vsync_pos  = regs_q[R_VSYNC_POS[SelW-1:0]];
		cfg.max_scan   = regs_q[R_MAX_SCAN[SelW-1:0]];
		cfg.start_addr = {regs_q[R_START_HI[SelW-1:0]], regs_q[R_START_LO[SelW-1:0]]};
	end

	// A start address write reloads the row start at once, using the new byte.
	always_comb begin
		start_ld.load = wr_data && (idx_q == R_START_HI || idx_q == R_START_LO);
		start_ld.addr = cfg.start_addr;
		if (idx_q == R_START_HI) begin
			start_ld.addr[ADDR_W-1:DATA_W] = write_data;
		end
		if (idx_q == R_START_LO) begin
			start_ld.addr[DATA_W-1:0] = write_data;
		end
	end

	// Only the cursor and light pen registers read back; the status port reads as zero.
	always_comb begin
		read_data = '0;
		if ((mode == MODE_READ) && reg_select) begin
			unique case (idx_q)
				R_CURSOR_HI: read_data = regs_q[R_CURSOR_HI[SelW-1:0]];
				R_CURSOR_LO: read_data = regs_q[R_CURSOR_LO[SelW-1:0]];
				R_PEN_HI:    read_data = regs_q[R_PEN_HI[SelW-1:0]];
				R_PEN_LO:    read_data = regs_q[R_PEN_LO[SelW-1:0]];
				default:     read_data = '0;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cvtc_timing.sv
module cvtc_timing (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  cvtc_pkg::cfg_t        cfg,
	input  cvtc_pkg::start_ld_t   start_ld,
	output cvtc_pkg::tim_out_t    tim
);
	import cvtc_pkg::*;

	logic [CNT_W-1:0]  h_q, scan_q, crow_q;
	logic [ADDR_W-1:0] addr_q, rsa_q;
	logic              de_q, hs_q, vs_q;

	logic [CNT_W-1:0]  h_inc, scan_inc, crow_inc;
	logic [CNT_W-1:0]  h_n, scan_n, crow_n;
	logic [ADDR_W-1:0] addr_n, rsa_n;
	logic              h_wrap, scan_wrap, crow_wrap;
	logic [CNT_W-1:0]  sync_hi;
	logic              de_n, hs_n, vs_n;

	// Counter cascade for one character clock.
	always_comb begin
		h_inc     = h_q + CNT_W'(1);
		scan_inc  = scan_q + CNT_W'(1);
		crow_inc  = crow_q + CNT_W'(1);
		h_wrap    = h_inc > CNT_W'(cfg.htotal);
		scan_wrap = h_wrap && (scan_inc > CNT_W'(cfg.max_scan));
		crow_wrap = scan_wrap && (crow_inc > CNT_W'(cfg.vtotal));

		h_n    = h_wrap ? '0 : h_inc;
		scan_n = h_wrap ? (scan_wrap ? '0 : scan_inc) : scan_q;
		crow_n = scan_wrap ? (crow_wrap ? '0 : crow_inc) : crow_q;

		rsa_n = rsa_q;
		if (crow_wrap) begin
			rsa_n = cfg.start_addr;
		end else if (scan_wrap) begin
			rsa_n = rsa_q + ADDR_W'(cfg.hdisp);
		end
		addr_n = h_wrap ? rsa_n : addr_q + ADDR_W'(1);
	end

	// Enable and sync flags from the advanced counters.
	always_comb begin
		sync_hi = CNT_W'(cfg.hsync_pos) + CNT_W'(cfg.sync_width);
		de_n    = (h_n < CNT_W'(cfg.hdisp)) && (crow_n < CNT_W'(cfg.vdisp));
		hs_n    = (h_n >= CNT_W'(cfg.hsync_pos)) && (h_n < sync_hi);
		vs_n    = crow_n == CNT_W'(cfg.vsync_pos);
	end

	// Timing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= '0;
			scan_q <= '0;
			crow_q <= '0;
			addr_q <= '0;
			rsa_q  <= '0;
			de_q   <= 1'b0;
			hs_q   <= 1'b0;
			vs_q   <= 1'b0;
		end else if (tick) begin
			h_q    <= h_n;
			scan_q <= scan_n;
			crow_q <= crow_n;
			addr_q <= addr_n;
			rsa_q  <= rsa_n;
			de_q   <= de_n;
			hs_q   <= hs_n;
			vs_q   <= vs_n;
		end else if (start_ld.load) begin
			rsa_q <= start_ld.addr;
		end
	end

	// Values as they stand once the current item has been applied.
	always_comb begin
		if (tick) begin
			tim.de   = de_n;
			tim.hs   = hs_n;
			tim.vs   = vs_n;
			tim.addr = addr_n;
			tim.row  = scan_n;
		end else begin
			tim.de   = de_q;
			tim.hs   = hs_q;
			tim.vs   = vs_q;
			tim.addr = addr_q;
			tim.row  = scan_q;
		end
	end

	// The counters and address move only on a tick.
	a_hold_without_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(h_q) && $stable(scan_q) && $stable(crow_q) && $stable(addr_q))
		else $error("timing counters moved without a tick");

	// A horizontal wrap clears the character count.
	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tick && h_wrap |=> h_q == '0)
		else $error("horizontal count not cleared on wrap");

	// After a horizontal wrap the refresh address starts from the row start.
	a_wrap_addr: assert property (@(posedge clk) disable iff (!arst_n)
		tick && h_wrap |=> addr_q == rsa_q)
		else $error("refresh address not reloaded from row start");

endmodule

FILE: hw/rtl/crt_video_timing_controller.sv
// CRT video timing controller with a small register bus.
//
// Input channel (in_valid / in_stall) carries one item per transfer: a bus read,
// a bus write or one character-clock tick, chosen by mode. Output channel
// (out_valid / out_stall) returns exactly one result item per input item, in
// order: the read byte (zero for writes and ticks) plus enable, syncs, refresh
// address and scanline as they stand after the item has been applied.
// An item is registered on entry in the input register, applied to the register
// file and counters from there once the output register can take its result, and
// its result is then held in the output register, which drives out_valid. One
// item is accepted every cycle while the output is drained; the single pass
// through the counter cascade sets that rate.
// When the receiver stalls, the result is held and one further item waits in the
// input register; in_stall rises only once both are full.
// Reset clears the register file, index, counters, addresses and flags, and
// empties both stages; the first item may be offered in the cycle after reset.
module crt_video_timing_controller #(
	parameter int unsigned NUM_REGS = 18
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic                             reg_select,
	input  logic [cvtc_pkg::DATA_W-1:0]      write_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [cvtc_pkg::DATA_W-1:0]      read_data,
	output logic                             display_enable,
	output logic                             horiz_sync,
	output logic                             vert_sync,
	output logic [cvtc_pkg::ADDR_W-1:0]      memory_address,
	output logic [cvtc_pkg::CNT_W-1:0]       row_address
);
	import cvtc_pkg::*;

	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic              sel_s1;
	logic [DATA_W-1:0] data_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	tim_out_t          tim_q;

	logic              advance;
	logic              commit;
	logic              tick;
	cfg_t              cfg;
	start_ld_t         start_ld;
	tim_out_t          tim;
	logic [DATA_W-1:0] read_data_c;

	// The output register can take a result when empty or being drained.
	assign advance  = !(out_valid_q && out_stall);
	assign commit   = valid_s1 && advance;
	assign tick     = commit && (mode_s1 == MODE_TICK);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1 <= mode;
			sel_s1  <= reg_select;
			data_s1 <= write_data;
		end
	end

	cvtc_regs #(
		.NUM_REGS(NUM_REGS)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.mode      (mode_s1),
		.reg_select(sel_s1),
		.write_data(data_s1),
		.cfg       (cfg),
		.start_ld  (start_ld),
		.read_data (read_data_c)
	);

	cvtc_timing u_timing (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.cfg     (cfg),
		.start_ld(start_ld),
		.tim     (tim)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			read_data_q <= read_data_c;
			tim_q       <= tim;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign display_enable = tim_q.de;
	assign horiz_sync     = tim_q.hs;
	assign vert_sync      = tim_q.vs;
	assign memory_address = tim_q.addr;
	assign row_address    = tim_q.row;

	// Back-pressure comes only from a full input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	// A held item stays in the input stage while the output is blocked.
	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && out_valid_q)
		else $error("item lost while the output was stalled");

	// A committed item always lands in the result register.
	a_commit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed item did not reach the output");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import cvtc_pkg::*;

	localparam int unsigned REG_COUNT = 18;
	localparam int unsigned ITEM_TARGET = 1550;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned PRINT_CAP = 64;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	// One item queued for the input channel
	typedef struct {
		logic [1:0]        kind;
		logic              sel;
		logic [DATA_W-1:0] data;
		bit                wait_idle;
	} bus_item_t;

	// One result item as the block should return it
	typedef struct packed {
		logic [DATA_W-1:0] rd;
		tim_out_t          tim;
	} crtc_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          mode = MODE_READ;
	logic                reg_select = 1'b0;
	logic [DATA_W-1:0]   write_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DATA_W-1:0]   read_data;
	logic                display_enable;
	logic                horiz_sync;
	logic                vert_sync;
	logic [ADDR_W-1:0]   memory_address;
	logic [CNT_W-1:0]    row_address;

	bus_item_t    pending_items[$];
	crtc_result_t expected_results[$];
	bus_item_t    next_item;
	bit           drain_next = 1'b0;
	int unsigned  items_queued = 0;
	int unsigned  items_accepted = 0;
	int unsigned  results_seen = 0;
	int unsigned  mismatches = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  send_wait = 0;
	int unsigned  recv_wait = 0;
	int unsigned  hold_left = 0;
	bit           send_burst = 1'b0;
	bit           recv_burst = 1'b0;

	// Predicted state of the controller
	logic [DATA_W-1:0] crtc_regs [REG_COUNT];
	logic [IDX_W-1:0]  bus_index;
	logic [CNT_W-1:0]  hcount;
	logic [CNT_W-1:0]  scanline;
	logic [CNT_W-1:0]  char_row;
	logic [ADDR_W-1:0] refresh_addr;
	logic [ADDR_W-1:0] row_base;
	logic              de_now;
	logic              hs_now;
	logic              vs_now;

	crt_video_timing_controller #(.NUM_REGS(REG_COUNT)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.reg_select     (reg_select),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.display_enable (display_enable),
		.horiz_sync     (horiz_sync),
		.vert_sync      (vert_sync),
		.memory_address (memory_address),
		.row_address    (row_address)
	);

	always #5 clk = ~clk;

	// Clear the predicted state as reset does
	task automatic clear_timing_state();
		foreach (crtc_regs[i]) crtc_regs[i] = '0;
		bus_index = '0;
		hcount = '0;
		scanline = '0;
		char_row = '0;
		refresh_addr = '0;
		row_base = '0;
		de_now = 1'b0;
		hs_now = 1'b0;
		vs_now = 1'b0;
	endtask

	// One character clock: step the counter cascade, then recompute the flags
	task automatic advance_char_clock();
		int unsigned sync_end;
		hcount = hcount + 1'b1;
		if (hcount > crtc_regs[R_HTOTAL]) begin
			hcount = '0;
			scanline = scanline + 1'b1;
			if (scanline > crtc_regs[R_MAX_SCAN]) begin
				scanline = '0;
				char_row = char_row + 1'b1;
				if (char_row > crtc_regs[R_VTOTAL]) begin
					char_row = '0;
					row_base = {crtc_regs[R_START_HI], crtc_regs[R_START_LO]};
				end else begin
					row_base = row_base + crtc_regs[R_HDISP];
				end
			end
			refresh_addr = row_base;
		end else begin
			refresh_addr = refresh_addr + 1'b1;
		end
		de_now = (hcount < crtc_regs[R_HDISP]) && (char_row < crtc_regs[R_VDISP]);
		sync_end = crtc_regs[R_HSYNC_POS] + (crtc_regs[R_SYNC_WIDTH][3:0] & SYNC_WIDTH_MASK);
		hs_now = (hcount >= crtc_regs[R_HSYNC_POS]) && (hcount < sync_end);
		vs_now = (char_row == crtc_regs[R_VSYNC_POS]);
	endtask

	// Apply one accepted item and queue the result it should produce
	task automatic apply_bus_item(logic [1:0] kind, logic sel, logic [DATA_W-1:0] data);
		crtc_result_t res;
		res.rd = '0;
		case (kind)
			MODE_READ: begin
				if (sel == PORT_DATA && bus_index >= R_CURSOR_HI && bus_index <= R_PEN_LO)
					res.rd = crtc_regs[bus_index];
			end
			MODE_WRITE: begin
				if (sel == PORT_INDEX) begin
					bus_index = data[IDX_W-1:0];
				end else if (bus_index < REG_COUNT) begin
					crtc_regs[bus_index] = data;
					if (bus_index == R_START_HI || bus_index == R_START_LO)
						row_base = {crtc_regs[R_START_HI], crtc_regs[R_START_LO]};
				end
			end
			MODE_TICK: advance_char_clock();
			default: ;
		endcase
		res.tim.de = de_now;
		res.tim.hs = hs_now;
		res.tim.vs = vs_now;
		res.tim.addr = refresh_addr;
		res.tim.row = scanline;
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at result %0d: %s is %0h, expected %0h",
				results_seen, what, got, want);
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic check_result();
		crtc_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing expected", 1, 0);
		end else begin
			want = expected_results.pop_front();
			if (read_data !== want.rd)
				report_mismatch("read_data", read_data, want.rd);
			if (display_enable !== want.tim.de)
				report_mismatch("display_enable", display_enable, want.tim.de);
			if (horiz_sync !== want.tim.hs)
				report_mismatch("horiz_sync", horiz_sync, want.tim.hs);
			if (vert_sync !== want.tim.vs)
				report_mismatch("vert_sync", vert_sync, want.tim.vs);
			if (memory_address !== want.tim.addr)
				report_mismatch("memory_address", memory_address, want.tim.addr);
			if (row_address !== want.tim.row)
				report_mismatch("row_address", row_address, want.tim.row);
		end
	endtask

	// Stimulus builders
	task automatic push_item(logic [1:0] kind, logic sel, logic [DATA_W-1:0] data);
		bus_item_t it;
		it.kind = kind;
		it.sel = sel;
		it.data = data;
		it.wait_idle = drain_next;
		drain_next = 1'b0;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic push_reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] idx_byte;
		// The upper index bits are ignored, so fill them at random.
		idx_byte = {3'($urandom), idx};
		push_item(MODE_WRITE, PORT_INDEX, idx_byte);
		push_item(MODE_WRITE, PORT_DATA, value);
	endtask

	function automatic logic [DATA_W-1:0] timing_value(int unsigned hi);
		if ($urandom_range(0, 15) == 0)
			return DATA_W'($urandom);
		return DATA_W'($urandom_range(0, hi));
	endfunction

	// A bus operation dropped in among the ticks
	task automatic push_bus_op();
		logic [IDX_W-1:0] idx;
		idx = IDX_W'($urandom_range(R_CURSOR_HI, R_PEN_LO));
		case ($urandom_range(0, 7))
			0: begin
				push_item(MODE_WRITE, PORT_INDEX, {3'($urandom), idx});
				push_item(MODE_READ, PORT_DATA, DATA_W'($urandom));
			end
			1: begin
				push_reg_write(idx, DATA_W'($urandom));
				push_item(MODE_READ, PORT_DATA, DATA_W'($urandom));
			end
			2: push_item(MODE_READ, PORT_INDEX, DATA_W'($urandom));
			3: push_reg_write($urandom_range(0, 1) ? R_START_HI : R_START_LO, DATA_W'($urandom));
			4: push_reg_write(IDX_W'($urandom), DATA_W'($urandom));
			5: push_item(MODE_UNUSED, 1'($urandom), DATA_W'($urandom));
			6: push_item(MODE_READ, PORT_DATA, DATA_W'($urandom));
			default: push_item(2'($urandom), 1'($urandom), DATA_W'($urandom));
		endcase
	endtask

	// Reprogram part of the timing, then run a stretch of ticks
	task automatic push_timing_group();
		int unsigned ticks;
		if ($urandom_range(0, 1)) push_reg_write(R_HTOTAL, timing_value(10));
		if ($urandom_range(0, 1)) push_reg_write(R_HDISP, timing_value(12));
		if ($urandom_range(0, 1)) push_reg_write(R_HSYNC_POS, timing_value(12));
		if ($urandom_range(0, 1)) push_reg_write(R_SYNC_WIDTH, DATA_W'($urandom));
		if ($urandom_range(0, 1)) push_reg_write(R_VTOTAL, timing_value(4));
		if ($urandom_range(0, 1)) push_reg_write(R_VDISP, timing_value(5));
		if ($urandom_range(0, 1)) push_reg_write(R_VSYNC_POS, timing_value(5));
		if ($urandom_range(0, 1)) push_reg_write(R_MAX_SCAN, timing_value(3));
		if ($urandom_range(0, 3) == 0) push_reg_write(R_START_HI, DATA_W'($urandom));
		if ($urandom_range(0, 3) == 0) push_reg_write(R_START_LO, DATA_W'($urandom));
		ticks = $urandom_range(10, 60);
		repeat (ticks) begin
			if ($urandom_range(0, 7) == 0)
				push_bus_op();
			else
				push_item(MODE_TICK, 1'($urandom), DATA_W'($urandom));
		end
	endtask

	// Input driver: offers queued items, holds them while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_READ;
			reg_select <= 1'b0;
			write_data <= '0;
			send_wait = 0;
			send_burst = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_bus_item(mode, reg_select, write_data);
				items_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_wait > 0) begin
					in_valid <= 1'b0;
					send_wait--;
				end else if (pending_items.size() != 0 &&
						!(pending_items[0].wait_idle && expected_results.size() != 0)) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					mode <= next_item.kind;
					reg_select <= next_item.sel;
					write_data <= next_item.data;
					if ($urandom_range(0, 31) == 0)
						send_burst = !send_burst;
					send_wait = send_burst ? 0 : $urandom_range(0, 14);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result and stalls at random, with long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
			recv_burst = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
				results_seen++;
				if (results_seen % 500 == 200)
					hold_left = 150;
				if ($urandom_range(0, 31) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
			end
			out_stall <= (hold_left > 0) || (recv_wait > 0);
			if (hold_left > 0)
				hold_left--;
			else if (recv_wait > 0)
				recv_wait--;
		end
	end

	// Watchdog on cycles in which neither channel moves an item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		clear_timing_state();

		// Directed part: status and unreadable reads, an idle tick, the unused mode
		push_item(MODE_READ, PORT_INDEX, 8'hFF);
		push_item(MODE_READ, PORT_DATA, 8'h00);
		push_item(MODE_TICK, PORT_INDEX, 8'h00);
		push_item(MODE_UNUSED, PORT_DATA, 8'hFF);
		// Readable registers at both byte extremes
		push_reg_write(R_CURSOR_HI, 8'hFF);
		push_item(MODE_READ, PORT_DATA, 8'h00);
		push_reg_write(R_PEN_LO, 8'h00);
		push_item(MODE_READ, PORT_DATA, 8'hFF);
		// Index beyond the register file: the write is dropped and reads give zero
		push_item(MODE_WRITE, PORT_INDEX, 8'hFF);
		push_item(MODE_WRITE, PORT_DATA, 8'h55);
		push_item(MODE_READ, PORT_DATA, 8'h00);
		// Start address written, taken up only at the next horizontal wrap
		push_reg_write(R_START_HI, 8'hFF);
		push_reg_write(R_START_LO, 8'h00);
		push_item(MODE_TICK, PORT_DATA, 8'hAA);
		// Widest line: ticks no longer wrap
		push_reg_write(R_HTOTAL, 8'hFF);
		push_item(MODE_TICK, PORT_INDEX, 8'h00);
		push_item(MODE_TICK, PORT_INDEX, 8'h00);

		// Random part: timing groups, pausing for an idle block now and then
		drain_next = 1'b1;
		for (int g = 0; items_queued < ITEM_TARGET; g++) begin
			if (g % 6 == 5)
				drain_next = 1'b1;
			push_timing_group();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: crt_video_timing_controller.f
hw/rtl/cvtc_pkg.sv
hw/rtl/cvtc_regs.sv
hw/rtl/cvtc_timing.sv
hw/rtl/crt_video_timing_controller.sv
dv/tb.sv
